// File: rtl/indexed_min_heap_key_update_assert.svh
// ----------------------------------------------------------------------------
// Heap key update assertion macros
// Shared property wrappers, clocked on clk and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef INDEXED_MIN_HEAP_KEY_UPDATE_ASSERT_SVH
`define INDEXED_MIN_HEAP_KEY_UPDATE_ASSERT_SVH

// same-cycle implication
`define IMHKU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IMHKU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/imhku_pkg.sv
// ----------------------------------------------------------------------------
// imhku_pkg
// Shared constants and helpers of the indexed min-heap key update block.
// ----------------------------------------------------------------------------
`default_nettype none

package imhku_pkg;

  localparam int KEY_W         = 64;
  localparam int DEF_MAX_LINKS = 16;

  // signed timestamp compare: a < b
  function automatic logic key_lt(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

endpackage

`default_nettype wire

// File: rtl/imhku_in_if.sv
// ----------------------------------------------------------------------------
// imhku_in_if
// Update channel: link number and its new timestamp.
// ----------------------------------------------------------------------------
`default_nettype none

interface imhku_in_if #(
  parameter int LINK_W = 4
) ();
  import imhku_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [LINK_W-1:0]       link_id;
  logic signed [KEY_W-1:0] new_key;

  modport source (output valid, output link_id, output new_key, input ready);
  modport sink   (input valid, input link_id, input new_key, output ready);
endinterface

`default_nettype wire

// File: rtl/imhku_out_if.sv
// ----------------------------------------------------------------------------
// imhku_out_if
// Result channel: root link, root timestamp and landing slot.
// ----------------------------------------------------------------------------
`default_nettype none

interface imhku_out_if #(
  parameter int LINK_W = 4
) ();
  import imhku_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [LINK_W-1:0]       top_link;
  logic signed [KEY_W-1:0] top_key;
  logic [LINK_W-1:0]       landed_slot;

  modport source (output valid, output top_link, output top_key, output landed_slot,
                  input ready);
  modport sink   (input valid, input top_link, input top_key, input landed_slot,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/imhku_ram.sv
// ----------------------------------------------------------------------------
// imhku_ram
// Generic RAM, one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module imhku_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    wa,
  input  wire logic [WIDTH-1:0] wd,
  input  wire logic [AW-1:0]    ra_a,
  input  wire logic [AW-1:0]    ra_b,
  output logic      [WIDTH-1:0] rd_data_a,
  output logic      [WIDTH-1:0] rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_a <= mem[ra_a];
    rd_data_b <= mem[ra_b];
  end

endmodule

`default_nettype wire

// File: rtl/imhku_core.sv
// ----------------------------------------------------------------------------
// imhku_core
// Sift sequencer: slot memory {link, key}, position memory, valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

`include "indexed_min_heap_key_update_assert.svh"

module imhku_core #(
  parameter int MAX_LINKS = 16,
  parameter int LINK_W    = $clog2(MAX_LINKS),
  parameter int CNT_W     = $clog2(MAX_LINKS + 1)
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic [LINK_W-1:0]                link_id,
  input  wire logic [imhku_pkg::KEY_W-1:0]      new_key,
  input  wire logic [CNT_W-1:0]                 n_slots,
  input  wire logic                             take,
  output logic                                  idle,
  output logic                                  done,
  output logic [LINK_W-1:0]                     top_link,
  output logic [imhku_pkg::KEY_W-1:0]           top_key,
  output logic [LINK_W-1:0]                     landed_slot
);
  import imhku_pkg::*;

  localparam int ENT_W = LINK_W + KEY_W;
  localparam int CW    = LINK_W + 2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_POS, ST_UP_RD, ST_UP_EV, ST_DN_RD, ST_DN_EV,
    ST_PLACE, ST_TOP_RD, ST_TOP_EV, ST_DONE
  } st_t;

  st_t                  st_r, st_nxt;
  logic [LINK_W-1:0]    link_r, link_nxt;
  logic [KEY_W-1:0]     key_r, key_nxt;
  logic [LINK_W-1:0]    slot_r, slot_nxt;
  logic [LINK_W-1:0]    land_r, land_nxt;
  logic [LINK_W-1:0]    top_link_r, top_link_nxt;
  logic [KEY_W-1:0]     top_key_r, top_key_nxt;
  logic [MAX_LINKS-1:0] slot_vld_r, slot_vld_nxt;
  logic [MAX_LINKS-1:0] pos_vld_r, pos_vld_nxt;

  // memory ports
  logic              slot_we;
  logic [ENT_W-1:0]  slot_wd;
  logic [LINK_W-1:0] slot_ra_a, slot_ra_b;
  logic [ENT_W-1:0]  slot_rd_a, slot_rd_b;
  logic [LINK_W-1:0] pos_wa;
  logic [LINK_W-1:0] pos_rd;

  logic [LINK_W-1:0] parent;
  logic [CW-1:0]     child_a, child_b, n_ext;
  logic [LINK_W-1:0] a_idx, b_idx;
  logic [LINK_W-1:0] a_link, b_link, pos_val;
  logic [KEY_W-1:0]  a_key, b_key;
  logic              use_b;
  logic [LINK_W-1:0] ch_link, ch_idx;
  logic [KEY_W-1:0]  ch_key;
  logic              id_ok;

  assign parent  = LINK_W'((slot_r - LINK_W'(1)) >> 1);
  assign child_a = CW'({slot_r, 1'b1});
  assign child_b = child_a + CW'(1);
  assign n_ext   = CW'(n_slots);
  assign id_ok   = CNT_W'(link_id) < CNT_W'(MAX_LINKS);

  // read data belongs to the address issued in the previous state
  always_comb begin
    case (st_r)
      ST_UP_EV: a_idx = parent;
      ST_DN_EV: a_idx = child_a[LINK_W-1:0];
      default:  a_idx = '0;
    endcase
  end
  assign b_idx = child_b[LINK_W-1:0];

  // never-written entries read as their reset contents
  assign a_link  = slot_vld_r[a_idx] ? slot_rd_a[ENT_W-1:KEY_W] : a_idx;
  assign a_key   = slot_vld_r[a_idx] ? slot_rd_a[KEY_W-1:0] : '0;
  assign b_link  = slot_vld_r[b_idx] ? slot_rd_b[ENT_W-1:KEY_W] : b_idx;
  assign b_key   = slot_vld_r[b_idx] ? slot_rd_b[KEY_W-1:0] : '0;
  assign pos_val = pos_vld_r[link_r] ? pos_rd : link_r;

  // right child only when strictly smaller
  assign use_b   = (child_b < n_ext) && key_lt(b_key, a_key);
  assign ch_link = use_b ? b_link : a_link;
  assign ch_key  = use_b ? b_key : a_key;
  assign ch_idx  = use_b ? b_idx : child_a[LINK_W-1:0];

  always_comb begin
    case (st_r)
      ST_DN_RD:  slot_ra_a = child_a[LINK_W-1:0];
      ST_TOP_RD: slot_ra_a = '0;
      default:   slot_ra_a = parent;
    endcase
  end
  assign slot_ra_b = b_idx;

  always_comb begin
    st_nxt       = st_r;
    link_nxt     = link_r;
    key_nxt      = key_r;
    slot_nxt     = slot_r;
    land_nxt     = land_r;
    top_link_nxt = top_link_r;
    top_key_nxt  = top_key_r;
    slot_we      = 1'b0;
    slot_wd      = {link_r, key_r};
    pos_wa       = link_r;
    case (st_r)
      ST_IDLE: begin
        if (start) begin
          link_nxt = link_id;
          key_nxt  = new_key;
          land_nxt = '0;
          st_nxt   = id_ok ? ST_POS : ST_TOP_RD;
        end
      end
      ST_POS: begin
        slot_nxt = pos_val;
        // a slot outside the active heap keeps its link; only the key changes
        st_nxt   = (CNT_W'(pos_val) < n_slots) ? ST_UP_RD : ST_PLACE;
      end
      ST_UP_RD: begin
        st_nxt = (slot_r == '0) ? ST_DN_RD : ST_UP_EV;
      end
      ST_UP_EV: begin
        if (key_lt(key_r, a_key)) begin
          slot_we  = 1'b1;
          slot_wd  = {a_link, a_key};
          pos_wa   = a_link;
          slot_nxt = parent;
          st_nxt   = ST_UP_RD;
        end else begin
          st_nxt = ST_DN_RD;
        end
      end
      ST_DN_RD: begin
        st_nxt = (child_a < n_ext) ? ST_DN_EV : ST_PLACE;
      end
      ST_DN_EV: begin
        if (key_lt(key_r, ch_key)) begin
          st_nxt = ST_PLACE;
        end else begin
          slot_we  = 1'b1;
          slot_wd  = {ch_link, ch_key};
          pos_wa   = ch_link;
          slot_nxt = ch_idx;
          st_nxt   = ST_DN_RD;
        end
      end
      ST_PLACE: begin
        slot_we  = 1'b1;
        land_nxt = slot_r;
        st_nxt   = ST_TOP_RD;
      end
      ST_TOP_RD: begin
        st_nxt = ST_TOP_EV;
      end
      ST_TOP_EV: begin
        top_link_nxt = a_link;
        top_key_nxt  = a_key;
        st_nxt       = ST_DONE;
      end
      ST_DONE: begin
        if (take) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    slot_vld_nxt = slot_vld_r;
    pos_vld_nxt  = pos_vld_r;
    if (slot_we) begin
      slot_vld_nxt[slot_r] = 1'b1;
      pos_vld_nxt[pos_wa]  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      slot_vld_r <= '0;
      pos_vld_r  <= '0;
    end else begin
      st_r       <= st_nxt;
      slot_vld_r <= slot_vld_nxt;
      pos_vld_r  <= pos_vld_nxt;
    end
    link_r     <= link_nxt;
    key_r      <= key_nxt;
    slot_r     <= slot_nxt;
    land_r     <= land_nxt;
    top_link_r <= top_link_nxt;
    top_key_r  <= top_key_nxt;
  end

  imhku_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_LINKS),
    .AW    (LINK_W)
  ) u_slot_mem (
    .clk       (clk),
    .we        (slot_we),
    .wa        (slot_r),
    .wd        (slot_wd),
    .ra_a      (slot_ra_a),
    .ra_b      (slot_ra_b),
    .rd_data_a (slot_rd_a),
    .rd_data_b (slot_rd_b)
  );

  // position map written in lockstep with the slot memory
  imhku_ram #(
    .WIDTH (LINK_W),
    .DEPTH (MAX_LINKS),
    .AW    (LINK_W)
  ) u_pos_mem (
    .clk       (clk),
    .we        (slot_we),
    .wa        (pos_wa),
    .wd        (slot_r),
    .ra_a      (link_id),
    .ra_b      (link_id),
    .rd_data_a (pos_rd),
    .rd_data_b ()
  );

  assign idle        = (st_r == ST_IDLE);
  assign done        = (st_r == ST_DONE);
  assign top_link    = top_link_r;
  assign top_key     = top_key_r;
  assign landed_slot = land_r;

  `IMHKU_ASSERT_NOW(a_start_idle, clk, rst_n, start, st_r == ST_IDLE,
    "item started while busy")
  `IMHKU_ASSERT_NEXT(a_up_parent, clk, rst_n, (st_r == ST_UP_EV) && slot_we,
    (slot_r == $past(parent)) && (st_r == ST_UP_RD), "sift up did not move to parent")
  `IMHKU_ASSERT_NOW(a_dn_active, clk, rst_n, st_r == ST_DN_EV, child_a < n_ext,
    "sift down compared a child outside the heap")

endmodule

`default_nettype wire

// File: rtl/indexed_min_heap_key_update.sv
// ----------------------------------------------------------------------------
// indexed_min_heap_key_update
// Indexed binary min-heap of links keyed by signed 64-bit timestamps.
// ----------------------------------------------------------------------------
//  port     dir  handshake        payload
//  in_ch    in   valid / ready    link_id, new_key
//  out_ch   out  valid / ready    top_link, top_key, landed_slot
//  cfg_*    in   cfg_we           cfg_wdata = links_in_use
//
//  One item at a time: the sequencer looks up the link's slot, sifts the link
//  up and then down if that slot is active, places it and reads the root;
//  each compare step waits on the registered read of the slot memory. Reset
//  clears the FSM and the memory valid bits, no clearing pass. The next item
//  is taken while a result waits in the output register; a stalled output
//  holds the sequencer in its final state.
`default_nettype none

module indexed_min_heap_key_update #(
  parameter int  MAX_LINKS = imhku_pkg::DEF_MAX_LINKS,
  localparam int LINK_W    = $clog2(MAX_LINKS),
  localparam int CNT_W     = $clog2(MAX_LINKS + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  imhku_in_if.sink              in_ch,
  imhku_out_if.source           out_ch,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata
);
  import imhku_pkg::*;

  logic [CNT_W-1:0]  n_slots_r, n_slots_nxt;
  logic              out_valid_r;
  logic [LINK_W-1:0] out_link_r, out_land_r;
  logic [KEY_W-1:0]  out_key_r;

  logic              core_idle, core_done, core_take, start;
  logic [LINK_W-1:0] core_link, core_land;
  logic [KEY_W-1:0]  core_key;

  // zero counts as one slot, anything past the heap size as the full heap
  always_comb begin
    if (cfg_wdata == '0) begin
      n_slots_nxt = CNT_W'(1);
    end else if (cfg_wdata > CNT_W'(MAX_LINKS)) begin
      n_slots_nxt = CNT_W'(MAX_LINKS);
    end else begin
      n_slots_nxt = cfg_wdata;
    end
  end

  assign start     = in_ch.valid && core_idle;
  assign core_take = core_done && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_slots_r   <= CNT_W'(MAX_LINKS);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        n_slots_r <= n_slots_nxt;
      end
      if (core_take) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (core_take) begin
      out_link_r <= core_link;
      out_key_r  <= core_key;
      out_land_r <= core_land;
    end
  end

  imhku_core #(
    .MAX_LINKS (MAX_LINKS),
    .LINK_W    (LINK_W),
    .CNT_W     (CNT_W)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .link_id     (in_ch.link_id),
    .new_key     (in_ch.new_key),
    .n_slots     (n_slots_r),
    .take        (core_take),
    .idle        (core_idle),
    .done        (core_done),
    .top_link    (core_link),
    .top_key     (core_key),
    .landed_slot (core_land)
  );

  assign in_ch.ready        = core_idle;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.top_link    = out_link_r;
  assign out_ch.top_key     = out_key_r;
  assign out_ch.landed_slot = out_land_r;

endmodule

`default_nettype wire

// File: tb/sv/indexed_min_heap_key_update_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_min_heap_key_update_checker
// Watches the update, result and slot-count ports of the heap block, keeps a
// private copy of the heap, and matches every result item in order against
// the root and landing slot that the copy predicts.
// ----------------------------------------------------------------------------

module indexed_min_heap_key_update_checker (
  input  logic        clk,
  input  logic        rst_n,
  imhku_in_if         in_mon,
  imhku_out_if        out_mon,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  output int          fail_count,
  output int          pending,
  output int          results_checked
);
  import imhku_pkg::*;

  localparam int NLINK = DEF_MAX_LINKS;

  typedef struct packed {
    logic [3:0]              top_link;
    logic signed [KEY_W-1:0] top_key;
    logic [3:0]              landed_slot;
  } heap_result_t;

  logic [4:0]              slots_cfg;
  logic [3:0]              link_at [NLINK];
  logic [3:0]              slot_of [NLINK];
  logic signed [KEY_W-1:0] key_of  [NLINK];
  heap_result_t            expected_tops [$];
  int                      mismatches;
  int                      matched;

  assign fail_count      = mismatches;
  assign results_checked = matched;

  task automatic clear_heap();
    for (int i = 0; i < NLINK; i++) begin
      link_at[i] = i[3:0];
      slot_of[i] = i[3:0];
      key_of[i]  = '0;
    end
    slots_cfg = 5'd16;
    expected_tops.delete();
  endtask

  function automatic void put_link(input int slot, input logic [3:0] link);
    link_at[slot] = link;
    slot_of[link] = slot[3:0];
  endfunction

  // store the key, sift up then down within the active slots, report root and landing slot
  function automatic heap_result_t apply_update(input logic [3:0] link,
                                                input logic signed [KEY_W-1:0] key);
    int           n;
    int           slot;
    int           parent;
    int           child;
    bit           done;
    heap_result_t r;
    n = (slots_cfg == 0) ? 1 : ((slots_cfg > NLINK) ? NLINK : int'(slots_cfg));
    slot = slot_of[link];
    key_of[link] = key;
    if (slot < n) begin
      done = 0;
      while (slot > 0 && !done) begin
        parent = (slot - 1) / 2;
        if (key < key_of[link_at[parent]]) begin
          put_link(slot, link_at[parent]);
          slot = parent;
        end else begin
          done = 1;
        end
      end
      put_link(slot, link);
      done = 0;
      while (!done) begin
        child = 2 * slot + 1;
        if (child >= n) begin
          done = 1;
        end else begin
          // right child only on a strict win; stop only on a strict win too
          if (child + 1 < n && key_of[link_at[child + 1]] < key_of[link_at[child]])
            child = child + 1;
          if (key < key_of[link_at[child]]) begin
            done = 1;
          end else begin
            put_link(slot, link_at[child]);
            slot = child;
          end
        end
      end
      put_link(slot, link);
    end
    r.top_link    = link_at[0];
    r.top_key     = key_of[link_at[0]];
    r.landed_slot = slot[3:0];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    heap_result_t want;
    if (!rst_n) begin
      clear_heap();
      pending <= 0;
    end else begin
      if (cfg_we)
        slots_cfg = cfg_wdata;
      if (in_mon.valid && in_mon.ready)
        expected_tops.push_back(apply_update(in_mon.link_id, in_mon.new_key));
      if (out_mon.valid && out_mon.ready) begin
        if (expected_tops.size() == 0) begin
          $display("%0t: result item with nothing expected (link %0d key %0d slot %0d)",
                   $time, out_mon.top_link, out_mon.top_key, out_mon.landed_slot);
          mismatches++;
        end else begin
          want = expected_tops.pop_front();
          matched++;
          if (out_mon.top_link !== want.top_link) begin
            $display("%0t: top_link expected %0d, got %0d",
                     $time, want.top_link, out_mon.top_link);
            mismatches++;
          end
          if (out_mon.top_key !== want.top_key) begin
            $display("%0t: top_key expected %0d, got %0d",
                     $time, want.top_key, out_mon.top_key);
            mismatches++;
          end
          if (out_mon.landed_slot !== want.landed_slot) begin
            $display("%0t: landed_slot expected %0d, got %0d",
                     $time, want.landed_slot, out_mon.landed_slot);
            mismatches++;
          end
        end
      end
      pending <= expected_tops.size();
    end
  end

endmodule

// File: tb/sv/indexed_min_heap_key_update_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_min_heap_key_update_tb
// Drives key updates into the heap block under bursty input and a stalling
// result side, steps the slot count through its corner values between
// phases, and lets the checker judge every result item.
// ----------------------------------------------------------------------------

module indexed_min_heap_key_update_tb;
  import imhku_pkg::*;

  localparam int                      CLK_PERIOD  = 2;
  localparam int                      CYCLE_LIMIT = 400000;
  localparam int                      HOLD_CYCLES = 400;
  localparam int                      PHASE_ITEMS = 164;
  localparam logic signed [KEY_W-1:0] KEY_MIN     = 64'sh8000_0000_0000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX     = 64'sh7FFF_FFFF_FFFF_FFFF;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [4:0] cfg_wdata;
  logic       hold_req;
  bit         hold_done;
  int         fail_count;
  int         pending;
  int         results_checked;
  int         items_sent;
  int         cfg_writes;
  int         burst_left;
  int         cycle_cnt;

  imhku_in_if  in_ch ();
  imhku_out_if out_ch ();

  indexed_min_heap_key_update i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  indexed_min_heap_key_update_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("indexed_min_heap_key_update_tb failed");
      $finish;
    end
  end

  // result side: segments of free flow, light and heavy stalling, one long hold
  initial begin : rx_pattern
    int mode;
    int seg;
    out_ch.ready <= 1'b0;
    hold_done = 0;
    forever begin
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        for (int k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
        hold_done = 1;
      end else begin
        mode = $urandom_range(0, 2);
        seg  = $urandom_range(4, 40);
        for (int k = 0; k < seg; k++) begin
          case (mode)
            0:       out_ch.ready <= 1'b1;
            1:       out_ch.ready <= 1'($urandom_range(0, 1));
            default: out_ch.ready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  task automatic send_item(input logic [3:0] link, input logic signed [KEY_W-1:0] key);
    int gap;
    in_ch.valid   <= 1'b1;
    in_ch.link_id <= link;
    in_ch.new_key <= key;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // slot count changes only with the block drained
  task automatic write_slots(input logic [4:0] val);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_writes++;
  endtask

  // small ranges give ties and real reordering, wide ones toggle every bit
  function automatic logic signed [KEY_W-1:0] rand_key();
    case ($urandom_range(0, 5))
      0, 1:    return 64'($signed($urandom_range(0, 16)) - 8);
      2:       return 64'($signed($urandom_range(0, 2000000)) - 1000000);
      3:       return {$urandom, $urandom};
      default: begin
        case ($urandom_range(0, 5))
          0:       return KEY_MIN;
          1:       return KEY_MAX;
          2:       return KEY_MIN + 1;
          3:       return KEY_MAX - 1;
          4:       return -64'sd1;
          default: return '0;
        endcase
      end
    endcase
  endfunction

  initial begin : stimulus
    logic [4:0] phase_cfg [11];
    phase_cfg = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd3, 5'd7, 5'd12, 5'd2, 5'd9, 5'd16};
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    hold_req      <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.link_id <= '0;
    in_ch.new_key <= '0;
    items_sent    = 0;
    cfg_writes    = 0;
    burst_left    = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset slot count: all keys tie at zero, so equal keys sink
    send_item(4'd5, '0);
    send_item(4'd3, KEY_MIN);
    send_item(4'd9, KEY_MAX);
    send_item(4'd3, KEY_MAX);
    send_item(4'd0, -64'sd1);
    send_item(4'd15, KEY_MIN + 1);
    send_item(4'd15, KEY_MIN);
    send_item(4'd7, 64'sd1);
    send_item(4'd2, -64'sd1);
    send_item(4'd4, -64'sd1);
    send_item(4'd15, KEY_MAX - 1);
    send_item(4'd12, 64'sh5555_5555_5555_5555);
    send_item(4'd6, 64'shAAAA_AAAA_AAAA_AAAA);
    // few slots: links beyond them only store their key
    write_slots(5'd3);
    send_item(4'd14, KEY_MIN);
    send_item(4'd1, 64'sd7);
    send_item(4'd0, KEY_MIN);
    send_item(4'd8, -64'sd5);
    // zero slots acts as one
    write_slots(5'd0);
    send_item(4'd11, KEY_MIN);
    send_item(4'd0, KEY_MAX);
    // too many slots clamps to the full heap
    write_slots(5'd31);
    send_item(4'd10, KEY_MIN);
    send_item(4'd9, KEY_MIN);
    write_slots(5'd16);
    send_item(4'd13, -64'sd3);
    send_item(4'd10, KEY_MAX);

    for (int p = 0; p < $size(phase_cfg); p++) begin
      write_slots(phase_cfg[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 1 && i == 60)
          hold_req <= 1'b1;
        send_item(4'($urandom_range(0, 15)), rand_key());
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d key updates sent across %0d slot-count writes, %0d results compared",
             items_sent, cfg_writes, results_checked);
    $display("slot counts from zero to 31 visited; long result stall done: %0d",
             hold_done);
    if (fail_count == 0 && pending == 0) begin
      $display("indexed_min_heap_key_update_tb passed");
    end else begin
      $display("indexed_min_heap_key_update_tb failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/imhku_pkg.sv
rtl/imhku_in_if.sv
rtl/imhku_out_if.sv
rtl/imhku_ram.sv
rtl/imhku_core.sv
rtl/indexed_min_heap_key_update.sv
tb/sv/indexed_min_heap_key_update_checker.sv
tb/sv/indexed_min_heap_key_update_tb.sv
